### rtl/knap_pkg.sv
// ----------------------------------------------------------------------------
// knap_pkg
// Shared widths, types and state codes of the 0/1 knapsack row update core.
// ----------------------------------------------------------------------------
package knap_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int ROW_DEPTH    = MAX_CAPACITY;
  localparam int ROW_AW       = $clog2(ROW_DEPTH);
  localparam int CAP_W        = 11;
  localparam int VAL_W        = 16;
  localparam int WT_W         = 16;
  localparam int BEST_W       = 32;
  localparam int EXT_W        = WT_W + 1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WT_W-1:0]  weight;
    logic             first;
    logic [CAP_W-1:0] cap;
    logic             cap_zero;
  } knap_job_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } knap_bk_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } knap_state_t;

endpackage

### rtl/knap_in_if.sv
// ----------------------------------------------------------------------------
// knap_in_if
// Item channel: valid/ready handshake with value, weight and first flag.
// ----------------------------------------------------------------------------
interface knap_in_if;
  logic                      valid;
  logic                      ready;
  logic [knap_pkg::VAL_W-1:0] item_value;
  logic [knap_pkg::WT_W-1:0]  item_weight;
  logic                      first_item;

  modport source (output valid, output item_value, output item_weight,
                  output first_item, input ready);
  modport sink (input valid, input item_value, input item_weight,
                input first_item, output ready);
endinterface

### rtl/knap_out_if.sv
// ----------------------------------------------------------------------------
// knap_out_if
// Result channel: valid/ready handshake with the best value at full capacity.
// ----------------------------------------------------------------------------
interface knap_out_if;
  logic                        valid;
  logic                        ready;
  logic [knap_pkg::BEST_W-1:0] best_value;

  modport source (output valid, output best_value, input ready);
  modport sink (input valid, input best_value, output ready);
endinterface

### rtl/knap_front.sv
// ----------------------------------------------------------------------------
// knap_front
// Holds the capacity register, classifies accepted items and queues them
// in a two-entry queue for the update engine.
// ----------------------------------------------------------------------------
module knap_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [knap_pkg::CAP_W-1:0]   cfg_wdata,
  knap_in_if.sink                      in_ch,
  input  knap_pkg::knap_bk_ctl_t       bk_ctl,
  output logic                         job_valid,
  output knap_pkg::knap_job_t          job
);

  logic [knap_pkg::CAP_W-1:0] capacity_r;
  logic [knap_pkg::CAP_W-1:0] cap_use;
  knap_pkg::knap_job_t        q_mem_r [2];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [1:0]                 count_r;
  logic                       push;
  logic                       pop;
  knap_pkg::knap_job_t        new_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= knap_pkg::CAP_W'(knap_pkg::MAX_CAPACITY);
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  assign cap_use = (capacity_r > knap_pkg::CAP_W'(knap_pkg::MAX_CAPACITY)) ?
                   knap_pkg::CAP_W'(knap_pkg::MAX_CAPACITY) : capacity_r;

  always_comb begin
    new_job.value    = in_ch.item_value;
    new_job.weight   = in_ch.item_weight;
    new_job.first    = in_ch.first_item;
    new_job.cap      = cap_use;
    new_job.cap_zero = (cap_use == '0);
  end

  assign in_ch.ready = (count_r != 2'd2) && !bk_ctl.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = bk_ctl.pop && (count_r != 2'd0);
  assign job_valid   = (count_r != 2'd0);
  assign job         = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/knap_back.sv
// ----------------------------------------------------------------------------
// knap_back
// Update engine: owns the row memory, clears it after reset, sweeps one
// capacity entry per cycle from the top down and holds the result register.
// ----------------------------------------------------------------------------
module knap_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  knap_pkg::knap_job_t     job,
  output knap_pkg::knap_bk_ctl_t  bk_ctl,
  knap_out_if.source              out_ch
);

  knap_pkg::knap_state_t         state_r;
  knap_pkg::knap_state_t         state_nxt;
  knap_pkg::knap_job_t           job_r;
  logic [knap_pkg::CAP_W-1:0]    c_r;
  logic [knap_pkg::ROW_AW-1:0]   clr_r;
  logic [knap_pkg::BEST_W-1:0]   res_r;
  logic [knap_pkg::BEST_W-1:0]   out_data_r;
  logic                          out_valid_r;

  logic [knap_pkg::BEST_W-1:0]   row_mem [knap_pkg::ROW_DEPTH];
  logic [knap_pkg::BEST_W-1:0]   rd_a_q;
  logic [knap_pkg::BEST_W-1:0]   rd_b_q;

  logic                          s1_v_r;
  logic [knap_pkg::ROW_AW-1:0]   s1_addr_r;
  logic                          s1_fits_r;
  logic                          s1_base_ok_r;
  logic                          s1_first_r;
  logic                          s1_top_r;

  logic                          pop;
  logic                          issue;
  logic                          load_out;
  logic [knap_pkg::EXT_W-1:0]    c_ext;
  logic [knap_pkg::EXT_W-1:0]    w_ext;
  logic [knap_pkg::EXT_W-1:0]    rest;
  logic [knap_pkg::EXT_W-1:0]    rest_m1;
  logic [knap_pkg::CAP_W-1:0]    c_m1;
  logic                          fits;
  logic                          base_ok;
  logic [knap_pkg::ROW_AW-1:0]   rd_a_addr;
  logic [knap_pkg::ROW_AW-1:0]   rd_b_addr;

  logic [knap_pkg::BEST_W-1:0]   keep;
  logic [knap_pkg::BEST_W-1:0]   base;
  logic [knap_pkg::BEST_W:0]     sum;
  logic [knap_pkg::BEST_W-1:0]   cand;
  logic [knap_pkg::BEST_W-1:0]   next_val;
  logic                          mem_we;
  logic [knap_pkg::ROW_AW-1:0]   mem_waddr;
  logic [knap_pkg::BEST_W-1:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knap_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      knap_pkg::ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = knap_pkg::ST_IDLE;
        end
      end
      knap_pkg::ST_IDLE: begin
        if (job_valid) begin
          pop       = 1'b1;
          state_nxt = job.cap_zero ? knap_pkg::ST_FINISH : knap_pkg::ST_SWEEP;
        end
      end
      knap_pkg::ST_SWEEP: begin
        issue = 1'b1;
        if (c_r == knap_pkg::CAP_W'(1)) begin
          state_nxt = knap_pkg::ST_DRAIN;
        end
      end
      knap_pkg::ST_DRAIN: begin
        state_nxt = knap_pkg::ST_FINISH;
      end
      knap_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = knap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = knap_pkg::ST_IDLE;
      end
    endcase
  end

  assign bk_ctl.pop      = pop;
  assign bk_ctl.clearing = (state_r == knap_pkg::ST_CLEAR);

  // Read addresses for capacity c: address c - 1 and address c - weight - 1.
  assign c_ext     = knap_pkg::EXT_W'(c_r);
  assign w_ext     = {1'b0, job_r.weight};
  assign fits      = (w_ext <= c_ext);
  assign rest      = c_ext - w_ext;
  assign rest_m1   = rest - knap_pkg::EXT_W'(1);
  assign c_m1      = c_r - knap_pkg::CAP_W'(1);
  assign base_ok   = fits && (rest != '0) && !job_r.first;
  assign rd_a_addr = c_m1[knap_pkg::ROW_AW-1:0];
  assign rd_b_addr = rest_m1[knap_pkg::ROW_AW-1:0];

  // The old row reads as zero for the first item of a problem.
  assign keep = s1_first_r ? '0 : rd_a_q;
  assign base = s1_base_ok_r ? rd_b_q : '0;
  assign sum  = {1'b0, base} + {{(knap_pkg::BEST_W + 1 - knap_pkg::VAL_W){1'b0}}, job_r.value};
  assign cand = sum[knap_pkg::BEST_W] ? '1 : sum[knap_pkg::BEST_W-1:0];
  assign next_val = (s1_fits_r && (cand > keep)) ? cand : keep;

  always_comb begin
    if (state_r == knap_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_v_r;
      mem_waddr = s1_addr_r;
      mem_wdata = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= row_mem[rd_a_addr];
    rd_b_q <= row_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      c_r         <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == knap_pkg::ST_CLEAR) begin
        clr_r <= clr_r + knap_pkg::ROW_AW'(1);
      end
      if (pop) begin
        c_r <= job.cap;
      end else if (issue) begin
        c_r <= c_m1;
      end
      s1_v_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
    if (issue) begin
      s1_addr_r    <= rd_a_addr;
      s1_fits_r    <= fits;
      s1_base_ok_r <= base_ok;
      s1_first_r   <= job_r.first;
      s1_top_r     <= (c_r == job_r.cap);
    end
    if (pop) begin
      res_r <= '0;
    end else if (s1_v_r && s1_top_r) begin
      res_r <= next_val;
    end
    if (load_out) begin
      out_data_r <= res_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_value = out_data_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == knap_pkg::ST_IDLE))
    else $error("job taken outside idle state");

  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (state_r == knap_pkg::ST_SWEEP || state_r == knap_pkg::ST_DRAIN))
    else $error("row write outside the sweep");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knap_pkg::ST_SWEEP) |-> (c_r != '0 && c_r <= job_r.cap))
    else $error("sweep index out of range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == knap_pkg::ST_FINISH))
    else $error("result raised outside finish state");

endmodule

### rtl/knapsack_01_dp_row_update_core.sv
// ----------------------------------------------------------------------------
// knapsack_01_dp_row_update_core
// 0/1 knapsack dynamic-programming row update with a 1024-entry value row.
// ----------------------------------------------------------------------------
// Items arrive on in_ch as value, weight and a first-item flag; each accepted
// transaction produces exactly one transaction on out_ch carrying the best
// value at full capacity after that item. The user writes the capacity
// register via cfg_we and cfg_wdata only while the core is idle; the block
// does not enforce it. Values above 1024 act as 1024 and zero gives a result
// of 0 without touching the row. A front stage classifies items and holds up
// to two in a queue, and the update engine sweeps the row from the top
// capacity down, one entry per cycle, reading two entries and writing one of
// the row memory each cycle. An item occupies the engine from its pop in idle
// through the sweep, drain and finish states, or idle and finish alone at zero
// capacity; the engine takes no new item before it is back in idle.
// After reset the engine clears the row memory, and in_ch.ready stays low
// during that pass. A stalled receiver holds the result in the output
// register; the engine finishes its next item and then waits, while the
// queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module knapsack_01_dp_row_update_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [knap_pkg::CAP_W-1:0] cfg_wdata,
  knap_in_if.sink                    in_ch,
  knap_out_if.source                 out_ch
);

  knap_pkg::knap_bk_ctl_t bk_ctl;
  knap_pkg::knap_job_t    job;
  logic                   job_valid;

  knap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .bk_ctl    (bk_ctl),
    .job_valid (job_valid),
    .job       (job)
  );

  knap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .bk_ctl    (bk_ctl),
    .out_ch    (out_ch)
  );

endmodule
